/* hw/rtl/ackd_pkg.sv */
package ackd_pkg;

    // item kinds on the input channel
    localparam logic [1:0] FUNC_ARM  = 2'd0;
    localparam logic [1:0] FUNC_BYTE = 2'd1;
    localparam logic [1:0] FUNC_TICK = 2'd2;

    // result kinds
    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_FINAL = 1'b1;

    // final status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_TIMEOUT  = 3'd1;
    localparam logic [2:0] ST_HEADER   = 3'd2;
    localparam logic [2:0] ST_CHECKSUM = 3'd3;
    localparam logic [2:0] ST_LONG     = 3'd4;

    // frame layout
    localparam logic [7:0]  HDR_HI       = 8'hef;
    localparam logic [7:0]  HDR_LO       = 8'h01;
    localparam logic [7:0]  PKT_ACK      = 8'h07;
    localparam logic [16:0] POS_HDR_HI   = 17'd0;
    localparam logic [16:0] POS_HDR_LO   = 17'd1;
    localparam logic [16:0] POS_TYPE     = 17'd6;
    localparam logic [16:0] POS_LEN_HI   = 17'd7;
    localparam logic [16:0] POS_LEN_LO   = 17'd8;
    localparam logic [16:0] POS_CONFIRM  = 17'd9;
    localparam logic [8:0]  POS_DATA     = 9'd10;
    localparam logic [16:0] HEAD_BYTES   = 17'd9;
    localparam logic [16:0] MIN_FRAME    = 17'd12;
    localparam logic [15:0] LEN_OVERHEAD = 16'd3;
    localparam logic [5:0]  OUT_CAP      = 6'd52;
    localparam logic [15:0] TICK_MAX     = 16'hffff;

    // configuration registers
    localparam int          PADDR_W        = 3;
    localparam logic        REG_TIMEOUT    = 1'b0;
    localparam logic        REG_MAX_LEN    = 1'b1;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd1000;
    localparam logic [5:0]  MAX_LEN_RESET  = 6'd52;

    typedef struct packed {
        logic in_open;
        logic latch_result;
        logic load_data;
        logic load_final;
    } t_dp_cmd;

    typedef struct packed {
        logic finish;
        logic emit;
        logic last_data;
        logic out_free;
    } t_dp_stat;

endpackage

/* hw/rtl/ackd_regs.sv */
module ackd_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ackd_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [15:0]                   o_timeout_ticks,
    output logic [5:0]                    o_max_data_len
);

    logic [15:0] r_timeout_ticks;
    logic [5:0]  r_max_data_len;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ticks <= ackd_pkg::TIMEOUT_RESET;
            r_max_data_len  <= ackd_pkg::MAX_LEN_RESET;
        end else if (w_wr) begin
            case (paddr[2])
                ackd_pkg::REG_TIMEOUT: r_timeout_ticks <= pwdata[15:0];
                ackd_pkg::REG_MAX_LEN: r_max_data_len  <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            ackd_pkg::REG_TIMEOUT: prdata = {16'd0, r_timeout_ticks};
            ackd_pkg::REG_MAX_LEN: prdata = {26'd0, r_max_data_len};
            default:               prdata = 32'd0;
        endcase
    end

    assign o_timeout_ticks = r_timeout_ticks;
    assign o_max_data_len  = r_max_data_len;

endmodule

/* hw/rtl/ackd_ctrl.sv */
module ackd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ackd_pkg::t_dp_stat i_stat,
    output ackd_pkg::t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_DATA  = 3'd3;
    localparam logic [2:0] S_FINAL = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_open = 1'b1;
                if (i_stat.finish) n_state = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.latch_result = 1'b1;
                n_state = i_stat.emit ? S_READ : S_FINAL;
            end
            // memory read address settles, data registered
            S_READ: begin
                n_state = S_DATA;
            end
            S_DATA: begin
                if (i_stat.out_free) begin
                    o_cmd.load_data = 1'b1;
                    n_state = i_stat.last_data ? S_FINAL : S_READ;
                end
            end
            S_FINAL: begin
                if (i_stat.out_free) begin
                    o_cmd.load_final = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hw/rtl/ackd_dp.sv */
module ackd_dp #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ackd_pkg::t_dp_cmd  i_cmd,
    output ackd_pkg::t_dp_stat o_stat,
    input  logic [15:0]        i_timeout_ticks,
    input  logic [5:0]         i_max_data_len,
    input  logic               i_valid,
    input  logic [1:0]         i_func,
    input  logic [7:0]         i_rx_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_kind,
    output logic [7:0]         o_data_byte,
    output logic [2:0]         o_status_code,
    output logic [7:0]         o_confirm_code,
    output logic [5:0]         o_data_count,
    output logic               o_last
);

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 1);

    logic [7:0]    r_mem [BUFFER_BYTES];
    logic [7:0]    r_rd_data;

    logic [CW-1:0] r_byte_count;
    logic [CW-1:0] n_byte_count;
    logic [15:0]   r_tick;
    logic [15:0]   n_tick;
    logic          r_armed;
    logic          n_armed;
    logic [15:0]   r_sum;
    logic [15:0]   n_sum;
    logic [15:0]   r_len;
    logic [15:0]   n_len;
    logic [7:0]    r_b0;
    logic [7:0]    r_b1;
    logic [7:0]    r_b6;
    logic [7:0]    r_confirm;
    logic [7:0]    r_prev0;
    logic [7:0]    r_prev1;
    logic [2:0]    r_status;
    logic [5:0]    r_cnt;
    logic [5:0]    r_idx;

    logic          r_o_valid;
    logic          r_kind;
    logic [7:0]    r_data_byte;
    logic [2:0]    r_status_code;
    logic [7:0]    r_confirm_code;
    logic [5:0]    r_data_count;
    logic          r_last;

    logic          w_accept;
    logic          w_store;
    logic          w_finish;
    logic [16:0]   w_pos;
    logic [16:0]   w_cnt17;
    logic [16:0]   w_need;
    logic [16:0]   w_n17;
    logic [16:0]   w_frame;
    logic [2:0]    w_status;
    logic [5:0]    w_cap;
    logic [15:0]   w_body;
    logic [5:0]    w_out_cnt;
    logic [8:0]    w_rd_sum;
    logic [AW-1:0] w_rd_addr;
    logic          w_out_free;

    assign w_accept   = i_valid & i_cmd.in_open;
    assign w_out_free = ~r_o_valid | ~i_stall;
    assign w_pos      = 17'(r_byte_count);

    // per-item update
    always_comb begin
        n_byte_count = r_byte_count;
        n_tick       = r_tick;
        n_armed      = r_armed;
        n_sum        = r_sum;
        n_len        = r_len;
        w_store      = 1'b0;
        w_finish     = 1'b0;
        w_cnt17      = w_pos + 17'd1;
        w_need       = 17'd0;
        if (w_accept) begin
            case (i_func)
                ackd_pkg::FUNC_ARM: begin
                    n_byte_count = '0;
                    n_tick       = '0;
                    n_sum        = '0;
                    n_armed      = 1'b1;
                    if (i_timeout_ticks == 16'd0) w_finish = 1'b1;
                end
                ackd_pkg::FUNC_BYTE: begin
                    if (r_armed) begin
                        if (r_byte_count == CW'(BUFFER_BYTES)) begin
                            w_finish = 1'b1;
                        end else begin
                            w_store      = 1'b1;
                            n_byte_count = r_byte_count + CW'(1);
                            if (w_pos == ackd_pkg::POS_LEN_HI) n_len = {i_rx_byte, r_len[7:0]};
                            if (w_pos == ackd_pkg::POS_LEN_LO) n_len = {r_len[15:8], i_rx_byte};
                            if (w_pos >= ackd_pkg::POS_TYPE &&
                                (w_pos < ackd_pkg::HEAD_BYTES ||
                                 w_pos < ackd_pkg::POS_LEN_HI + 17'(n_len))) begin
                                n_sum = r_sum + 16'(i_rx_byte);
                            end
                            w_need = ackd_pkg::HEAD_BYTES + 17'(n_len);
                            if ((w_cnt17 >= ackd_pkg::HEAD_BYTES && w_cnt17 >= w_need) ||
                                w_cnt17 >= 17'(BUFFER_BYTES)) begin
                                w_finish = 1'b1;
                            end
                        end
                    end
                end
                ackd_pkg::FUNC_TICK: begin
                    if (r_armed) begin
                        if (r_tick != ackd_pkg::TICK_MAX) n_tick = r_tick + 16'd1;
                        if (n_tick >= i_timeout_ticks) w_finish = 1'b1;
                    end
                end
                default: ;
            endcase
            if (w_finish) n_armed = 1'b0;
        end
    end

    // frame check, evaluated once the wait has ended
    always_comb begin
        w_n17   = w_pos;
        w_frame = ackd_pkg::HEAD_BYTES + 17'(r_len);
        if (w_n17 < ackd_pkg::MIN_FRAME) begin
            w_status = ackd_pkg::ST_TIMEOUT;
        end else if (r_b0 != ackd_pkg::HDR_HI || r_b1 != ackd_pkg::HDR_LO ||
                     r_b6 != ackd_pkg::PKT_ACK) begin
            w_status = ackd_pkg::ST_HEADER;
        end else if (w_frame > 17'(BUFFER_BYTES)) begin
            w_status = ackd_pkg::ST_LONG;
        end else if (w_n17 < w_frame) begin
            w_status = ackd_pkg::ST_TIMEOUT;
        end else if (r_sum != {r_prev1, r_prev0}) begin
            w_status = ackd_pkg::ST_CHECKSUM;
        end else begin
            w_status = ackd_pkg::ST_OK;
        end
        w_cap     = (i_max_data_len > ackd_pkg::OUT_CAP) ? ackd_pkg::OUT_CAP : i_max_data_len;
        w_body    = r_len - ackd_pkg::LEN_OVERHEAD;
        w_out_cnt = (w_body > 16'(w_cap)) ? w_cap : w_body[5:0];
        if (w_status != ackd_pkg::ST_OK) w_out_cnt = 6'd0;
    end

    assign w_rd_sum  = ackd_pkg::POS_DATA + 9'(r_idx);
    assign w_rd_addr = w_rd_sum[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_store) r_mem[r_byte_count[AW-1:0]] <= i_rx_byte;
        r_rd_data <= r_mem[w_rd_addr];
    end

    // payload captures
    always_ff @(posedge i_clk) begin
        r_len <= n_len;
        if (w_store) begin
            r_prev1 <= r_prev0;
            r_prev0 <= i_rx_byte;
            if (w_pos == ackd_pkg::POS_HDR_HI)  r_b0      <= i_rx_byte;
            if (w_pos == ackd_pkg::POS_HDR_LO)  r_b1      <= i_rx_byte;
            if (w_pos == ackd_pkg::POS_TYPE)    r_b6      <= i_rx_byte;
            if (w_pos == ackd_pkg::POS_CONFIRM) r_confirm <= i_rx_byte;
        end
        if (i_cmd.latch_result) begin
            r_status <= w_status;
            r_cnt    <= w_out_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_tick       <= '0;
            r_armed      <= 1'b0;
            r_sum        <= '0;
            r_idx        <= '0;
        end else begin
            r_byte_count <= n_byte_count;
            r_tick       <= n_tick;
            r_armed      <= n_armed;
            r_sum        <= n_sum;
            if (i_cmd.latch_result) begin
                r_idx <= '0;
            end else if (i_cmd.load_data) begin
                r_idx <= r_idx + 6'd1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.load_data || i_cmd.load_final) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_data) begin
            r_kind         <= ackd_pkg::KIND_DATA;
            r_data_byte    <= r_rd_data;
            r_status_code  <= ackd_pkg::ST_OK;
            r_confirm_code <= 8'd0;
            r_data_count   <= 6'd0;
            r_last         <= 1'b0;
        end else if (i_cmd.load_final) begin
            r_kind         <= ackd_pkg::KIND_FINAL;
            r_data_byte    <= 8'd0;
            r_status_code  <= r_status;
            r_confirm_code <= (r_status == ackd_pkg::ST_OK) ? r_confirm : 8'd0;
            r_data_count   <= r_cnt;
            r_last         <= 1'b1;
        end
    end

    assign o_stat.finish    = w_finish;
    assign o_stat.emit      = (w_status == ackd_pkg::ST_OK) && (w_out_cnt != 6'd0);
    assign o_stat.last_data = (r_idx + 6'd1) == r_cnt;
    assign o_stat.out_free  = w_out_free;

    assign o_valid        = r_o_valid;
    assign o_kind         = r_kind;
    assign o_data_byte    = r_data_byte;
    assign o_status_code  = r_status_code;
    assign o_confirm_code = r_confirm_code;
    assign o_data_count   = r_data_count;
    assign o_last         = r_last;

endmodule

/* hw/rtl/ack_packet_deframer.sv */
// channel   direction  handshake           payload
// input     in         i_valid / o_stall   i_func, i_rx_byte
// result    out        o_valid / i_stall   o_kind, o_data_byte, o_status_code,
//                                          o_confirm_code, o_data_count, o_last
// config    in         psel/penable/pready paddr, pwdata, prdata (apb-style)
//
// arm, byte and tick transactions are accepted whenever offered while a packet is collected
// closing a packet runs a check state, then a read and a load state per data byte (one memory
// read port, registered read data), then the final status item
// input is stalled from the closing transaction until the status item is loaded
// a result stalled at the output holds the sequencer, not the collected state
// i_rst_n is synchronous; the byte memory is not cleared and needs no sweep
module ack_packet_deframer #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_func,
    input  logic [7:0]                    i_rx_byte,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_kind,
    output logic [7:0]                    o_data_byte,
    output logic [2:0]                    o_status_code,
    output logic [7:0]                    o_confirm_code,
    output logic [5:0]                    o_data_count,
    output logic                          o_last,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ackd_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    ackd_pkg::t_dp_cmd  w_cmd;
    ackd_pkg::t_dp_stat w_stat;
    logic [15:0]        w_timeout_ticks;
    logic [5:0]         w_max_data_len;

    // timeout and length cap registers
    ackd_regs u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_timeout_ticks (w_timeout_ticks),
        .o_max_data_len  (w_max_data_len)
    );

    // sequencer: collect, check, emit data bytes, emit status
    ackd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // byte memory, frame counters, checksum and output register
    ackd_dp #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_timeout_ticks (w_timeout_ticks),
        .i_max_data_len  (w_max_data_len),
        .i_valid         (i_valid),
        .i_func          (i_func),
        .i_rx_byte       (i_rx_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kind          (o_kind),
        .o_data_byte     (o_data_byte),
        .o_status_code   (o_status_code),
        .o_confirm_code  (o_confirm_code),
        .o_data_count    (o_data_count),
        .o_last          (o_last)
    );

    // input is open only while collecting
    assign o_stall = ~w_cmd.in_open;

endmodule

/* bench/ackd_check_pkg.sv */
package ackd_check_pkg;
    import ackd_pkg::*;

    localparam int FRAME_BUF = 64;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [2:0] status_code;
        logic [7:0] confirm_code;
        logic [5:0] data_count;
        logic       last;
    } ack_reply_t;

    class ack_reply_scoreboard;
        logic [7:0]  frame_mem [FRAME_BUF];
        int unsigned rx_count;
        int unsigned tick_count;
        bit          waiting;
        logic [15:0] body_sum;
        logic [15:0] timeout_ticks;
        logic [5:0]  max_data_len;
        ack_reply_t  replies_due [$];
        int unsigned mismatches;

        function new();
            foreach (frame_mem[i]) frame_mem[i] = 8'h00;
            rx_count      = 0;
            tick_count    = 0;
            waiting       = 1'b0;
            body_sum      = '0;
            timeout_ticks = TIMEOUT_RESET;
            max_data_len  = MAX_LEN_RESET;
            mismatches    = 0;
        endfunction

        function void set_register(logic which, logic [31:0] value);
            if (which == REG_TIMEOUT) begin
                timeout_ticks = value[15:0];
            end else begin
                max_data_len = value[5:0];
            end
        endfunction

        // big-endian length field of the frame being collected
        function int unsigned length_field();
            return {frame_mem[POS_LEN_HI], frame_mem[POS_LEN_LO]};
        endfunction

        function void owe_status(logic [2:0] code, logic [7:0] conf, logic [5:0] cnt);
            replies_due.push_back('{KIND_FINAL, 8'h00, code, conf, cnt, 1'b1});
        endfunction

        // end of wait: check the frame in priority order and queue the replies
        function void close_frame();
            int unsigned plen;
            int unsigned cnt;
            int unsigned cap;
            logic [15:0] sent_sum;
            waiting = 1'b0;
            plen = length_field();
            if (rx_count < MIN_FRAME) begin
                owe_status(ST_TIMEOUT, 8'h00, 6'd0);
            end else if (frame_mem[POS_HDR_HI] != HDR_HI || frame_mem[POS_HDR_LO] != HDR_LO
                         || frame_mem[POS_TYPE] != PKT_ACK) begin
                owe_status(ST_HEADER, 8'h00, 6'd0);
            end else if (HEAD_BYTES + plen > FRAME_BUF) begin
                owe_status(ST_LONG, 8'h00, 6'd0);
            end else if (rx_count < HEAD_BYTES + plen) begin
                owe_status(ST_TIMEOUT, 8'h00, 6'd0);
            end else begin
                sent_sum = {frame_mem[POS_LEN_HI + plen], frame_mem[POS_LEN_LO + plen]};
                if (body_sum != sent_sum) begin
                    owe_status(ST_CHECKSUM, 8'h00, 6'd0);
                end else begin
                    cap = (max_data_len > OUT_CAP) ? OUT_CAP : max_data_len;
                    cnt = plen - LEN_OVERHEAD;
                    if (cnt > cap) cnt = cap;
                    for (int i = 0; i < cnt; i++) begin
                        replies_due.push_back('{KIND_DATA, frame_mem[POS_DATA + i], ST_OK,
                                                8'h00, 6'd0, 1'b0});
                    end
                    owe_status(ST_OK, frame_mem[POS_CONFIRM], cnt[5:0]);
                end
            end
        endfunction

        function void note_item(logic [1:0] func, logic [7:0] rx_byte);
            int unsigned slot;
            if (func == FUNC_ARM) begin
                rx_count   = 0;
                tick_count = 0;
                body_sum   = '0;
                waiting    = 1'b1;
                if (timeout_ticks == 0) close_frame();
            end else if (waiting && func == FUNC_BYTE) begin
                slot = rx_count;
                if (slot >= FRAME_BUF) begin
                    close_frame();
                end else begin
                    frame_mem[slot] = rx_byte;
                    rx_count = slot + 1;
                    if (slot >= POS_TYPE && (slot < HEAD_BYTES || slot < POS_LEN_HI + length_field()))
                        body_sum = body_sum + rx_byte;
                    if (rx_count >= HEAD_BYTES && rx_count >= HEAD_BYTES + length_field())
                        close_frame();
                    else if (rx_count >= FRAME_BUF)
                        close_frame();
                end
            end else if (waiting && func == FUNC_TICK) begin
                if (tick_count < TICK_MAX) tick_count++;
                if (tick_count >= timeout_ticks) close_frame();
            end
        endfunction

        function void check_reply(ack_reply_t got);
            ack_reply_t want;
            if (replies_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: stray result kind %0d byte %02h status %0d confirm %02h count %0d last %0d",
                             $time, got.kind, got.data_byte, got.status_code, got.confirm_code,
                             got.data_count, got.last);
            end else begin
                want = replies_due.pop_front();
                if (got.kind !== want.kind || got.data_byte !== want.data_byte
                    || got.status_code !== want.status_code
                    || got.confirm_code !== want.confirm_code
                    || got.data_count !== want.data_count || got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: expected kind %0d byte %02h status %0d confirm %02h count %0d last %0d",
                                 $time, want.kind, want.data_byte, want.status_code,
                                 want.confirm_code, want.data_count, want.last);
                        $display("%0t: actual   kind %0d byte %02h status %0d confirm %02h count %0d last %0d",
                                 $time, got.kind, got.data_byte, got.status_code,
                                 got.confirm_code, got.data_count, got.last);
                    end
                end
            end
        endfunction
    endclass

endpackage

/* bench/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ackd_pkg::*;
    import ackd_check_pkg::*;

    // func value the block must ignore
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    // worst close: a check state, a read and a load state per data byte, then the status item
    localparam int SETTLE_CYCLES = 120;
    localparam int RUN_LIMIT_NS  = 2_000_000;

    typedef enum {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_TOGGLE} flow_mode_t;

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                i_valid   = 1'b0;
    logic                o_stall;
    logic [1:0]          i_func    = FUNC_ARM;
    logic [7:0]          i_rx_byte = 8'h00;
    logic                o_valid;
    logic                i_stall   = 1'b0;
    logic                o_kind;
    logic [7:0]          o_data_byte;
    logic [2:0]          o_status_code;
    logic [7:0]          o_confirm_code;
    logic [5:0]          o_data_count;
    logic                o_last;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [PADDR_W-1:0]  paddr     = '0;
    logic [31:0]         pwdata    = '0;
    logic [31:0]         prdata;
    logic                pready;

    ack_reply_scoreboard sb;
    ack_reply_t          seen_reply;
    logic [7:0]          frame_q [$];
    int                  burst_left = 0;
    int                  items_sent = 0;
    int                  stall_seg  = 0;
    flow_mode_t          flow_mode  = FLOW_FREE;

    ack_packet_deframer #(
        .BUFFER_BYTES(FRAME_BUF)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_data_byte    (o_data_byte),
        .o_status_code  (o_status_code),
        .o_confirm_code (o_confirm_code),
        .o_data_count   (o_data_count),
        .o_last         (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 i_clk = ~i_clk;

    // result side back-pressure: segments of random length, each with its own pattern
    always @(negedge i_clk) begin
        if (stall_seg == 0) begin
            stall_seg = $urandom_range(5, 60);
            flow_mode = flow_mode_t'($urandom_range(0, 3));
        end
        stall_seg--;
        case (flow_mode)
            FLOW_FREE:  i_stall <= 1'b0;
            FLOW_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
            FLOW_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
            default:    i_stall <= ~i_stall;
        endcase
    end

    // every result transaction goes to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            seen_reply = '{o_kind, o_data_byte, o_status_code, o_confirm_code,
                           o_data_count, o_last};
            sb.check_reply(seen_reply);
        end
    end

    // one input transaction; entered and left just after a falling edge.
    // the sender runs in bursts and drops valid for a random gap between them
    task automatic send_item(input logic [1:0] func, input logic [7:0] rx_byte);
        if (burst_left == 0)
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
        i_valid   <= 1'b1;
        i_func    <= func;
        i_rx_byte <= rx_byte;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_item(func, rx_byte);
        items_sent++;
        burst_left--;
        @(negedge i_clk);
        if (burst_left == 0) begin
            // valid drops for a random gap so it never drops and rises in one step
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
    endtask

    // hold the sender until every queued reply has come out
    task automatic drain_results();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.replies_due.size() != 0) @(negedge i_clk);
        burst_left = 0;
    endtask

    // setup cycle then access cycle; register takes the value when pready is seen
    task automatic apb_write(input logic which, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(which) << 2;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_register(which, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // registers change only once the block is quiet; upper data bits are junk on purpose
    task automatic reconfigure(input logic [15:0] timeout, input logic [5:0] max_len);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        apb_write(REG_TIMEOUT, {16'($urandom), timeout});
        apb_write(REG_MAX_LEN, {26'($urandom), max_len});
    endtask

    // well-formed frame with random address and body; frames that claim more than
    // the buffer are cut two bytes past it so a byte after the close is also seen
    task automatic build_frame(input logic [15:0] plen);
        int unsigned total;
        logic [15:0] frame_sum;
        total = (HEAD_BYTES + plen > FRAME_BUF + 2) ? FRAME_BUF + 2 : HEAD_BYTES + plen;
        frame_q.delete();
        for (int i = 0; i < total; i++) frame_q.push_back(8'($urandom));
        frame_q[POS_HDR_HI] = HDR_HI;
        frame_q[POS_HDR_LO] = HDR_LO;
        frame_q[POS_TYPE]   = PKT_ACK;
        frame_q[POS_LEN_HI] = plen[15:8];
        frame_q[POS_LEN_LO] = plen[7:0];
        if (plen >= 2 && HEAD_BYTES + plen <= FRAME_BUF) begin
            // sum covers type, length and body up to the checksum pair
            frame_sum = '0;
            for (int i = POS_TYPE; i <= POS_TYPE + plen; i++) frame_sum += frame_q[i];
            frame_q[POS_LEN_HI + plen] = frame_sum[15:8];
            frame_q[POS_LEN_LO + plen] = frame_sum[7:0];
        end
    endtask

    // byte transactions of the frame, with time ticks slipped in at random
    task automatic send_frame(input int tick_pct);
        foreach (frame_q[i]) begin
            if ($urandom_range(0, 99) < tick_pct) send_item(FUNC_TICK, 8'($urandom));
            send_item(FUNC_BYTE, frame_q[i]);
        end
    endtask

    // mostly good frames with random content; the rest corrupted, oversized,
    // truncated, short, or plain noise
    task automatic run_traffic(input int budget, input int tick_pct);
        int stop_at;
        int pick;
        int cut;
        logic [15:0] plen;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            plen = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(11, 55))
                                               : 16'($urandom_range(3, 10));
            if (pick >= 90) begin
                repeat ($urandom_range(1, 5)) send_item(2'($urandom_range(0, 3)), 8'($urandom));
            end else begin
                if (pick >= 70 && pick < 78)
                    plen = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(56, 70))
                                                       : 16'($urandom_range(56, 65535));
                else if (pick >= 85)
                    plen = 16'($urandom_range(0, 2));
                build_frame(plen);
                if (pick >= 60 && pick < 70) begin
                    // xor with a nonzero value always breaks the field it lands on
                    case ($urandom_range(0, 3))
                        0:       frame_q[POS_HDR_HI] ^= 8'($urandom_range(1, 255));
                        1:       frame_q[POS_TYPE] ^= 8'($urandom_range(1, 255));
                        2:       frame_q[POS_LEN_HI + plen + $urandom_range(0, 1)]
                                     ^= 8'($urandom_range(1, 255));
                        default: frame_q[$urandom_range(POS_CONFIRM, POS_TYPE + plen)]
                                     ^= 8'($urandom_range(1, 255));
                    endcase
                end
                if (pick >= 78 && pick < 85) begin
                    cut = $urandom_range(1, frame_q.size() - 1);
                    while (frame_q.size() > cut) void'(frame_q.pop_back());
                end
                send_item(FUNC_ARM, 8'($urandom));
                send_frame(tick_pct);
                // truncated frames get a run of ticks that may or may not reach the timeout
                if (pick >= 78 && pick < 85)
                    repeat ($urandom_range(0, 48)) send_item(FUNC_TICK, 8'($urandom));
            end
            if ($urandom_range(0, 6) == 0) drain_results();
        end
    endtask

    initial begin
        #(RUN_LIMIT_NS);
        $display("ack_packet_deframer regression: fail");
        $finish;
    end

    initial begin
        sb = new();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: ignored kinds, arm restart, minimal good frame, short frame
        send_item(FUNC_UNUSED, 8'hff);
        send_item(FUNC_BYTE, 8'h00);
        send_item(FUNC_TICK, 8'h80);
        send_item(FUNC_ARM, 8'h00);
        send_item(FUNC_BYTE, HDR_HI);
        send_item(FUNC_BYTE, HDR_LO);
        send_item(FUNC_ARM, 8'hff);
        build_frame(16'd3);
        for (int i = POS_HDR_LO + 1; i < POS_TYPE; i++) frame_q[i] = 8'hff;
        send_frame(0);
        build_frame(16'd0);
        send_item(FUNC_ARM, 8'h00);
        send_frame(0);

        // longest timeout, oversize length limit: largest payload
        reconfigure(16'hffff, 6'd63);
        build_frame(16'd55);
        send_item(FUNC_ARM, 8'h00);
        send_frame(0);
        run_traffic(16, 0);

        // zero timeout: every arm closes at once
        reconfigure(16'd0, 6'd40);
        run_traffic(5, 10);

        // one-tick timeout, no data bytes handed out
        reconfigure(16'd1, 6'd0);
        run_traffic(6, 0);

        // short timeouts racing the frames
        reconfigure(16'($urandom_range(8, 40)), 6'($urandom_range(0, 52)));
        run_traffic(12, 20);
        reconfigure(16'($urandom_range(8, 40)), 6'($urandom_range(0, 52)));
        run_traffic(10, 15);

        // timeout lowered below the ticks already counted while a wait is open
        reconfigure(16'd20, 6'd52);
        send_item(FUNC_ARM, 8'h00);
        repeat (6) send_item(FUNC_TICK, 8'h00);
        reconfigure(16'd3, 6'd52);
        send_item(FUNC_TICK, 8'h00);

        // back to reset values
        reconfigure(TIMEOUT_RESET, MAX_LEN_RESET);
        run_traffic(8, 2);

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.replies_due.size() == 0) begin
            $display("ack_packet_deframer regression: pass");
        end else begin
            $display("ack_packet_deframer regression: fail");
        end
        $finish;
    end

endmodule
